// File: design/vrd_pkg.sv
// shared types and region constants for the vertex region deformer
`default_nettype none

package vrd_pkg;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
    } vrd_in_t;

    typedef struct packed {
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
        logic signed [15:0] new_z;
    } vrd_out_t;

    localparam int NUM_REGIONS = 9;

    localparam int RG_CHIN    = 0;
    localparam int RG_BROW    = 1;
    localparam int RG_EYE_L   = 2;
    localparam int RG_EYE_R   = 3;
    localparam int RG_NOSE    = 4;
    localparam int RG_CHEEK_L = 5;
    localparam int RG_CHEEK_R = 6;
    localparam int RG_EAR_L   = 7;
    localparam int RG_EAR_R   = 8;

    localparam logic [2:0] CFG_CHIN_SCALE  = 3'd0;
    localparam logic [2:0] CFG_BROW_LIFT   = 3'd1;
    localparam logic [2:0] CFG_BROW_SPREAD = 3'd2;
    localparam logic [2:0] CFG_EYE_SPACING = 3'd3;
    localparam logic [2:0] CFG_EYE_SCALE   = 3'd4;
    localparam logic [2:0] CFG_NOSE_EXTEND = 3'd5;
    localparam logic [2:0] CFG_NOSE_SCALE  = 3'd6;
    localparam logic [2:0] CFG_CHEEK_EAR   = 3'd7;

    localparam int Q_ONE = 4096;

    // region centres and radii in q4.12
    localparam int REG_CX [NUM_REGIONS] = '{0, 0, -1638, 1638, 0, -2458, 2458, -3686, 3686};
    localparam int REG_CY [NUM_REGIONS] = '{-3072, 2867, 1638, 1638, 0, -819, -819, 0, 0};
    localparam int REG_CZ [NUM_REGIONS] = '{205, 1638, 2867, 2867, 3277, 1229, 1229, 0, 0};
    localparam int REG_R  [NUM_REGIONS] = '{1024, 1638, 614, 614, 819, 1229, 1229, 1229, 1229};

    // floor(2^32 / r), used for the divide by the radius
    localparam longint REG_RECIP [NUM_REGIONS] = '{
        64'h1_0000_0000 / 1024, 64'h1_0000_0000 / 1638, 64'h1_0000_0000 / 614,
        64'h1_0000_0000 / 614,  64'h1_0000_0000 / 819,  64'h1_0000_0000 / 1229,
        64'h1_0000_0000 / 1229, 64'h1_0000_0000 / 1229, 64'h1_0000_0000 / 1229
    };

endpackage

`default_nettype wire

// File: design/vertex_region_deform.sv
// top level of the vertex region deformer: apb registers and the vertex pipeline
//
// usage: drive pos and raise start for one cycle per vertex; a request is taken
// at each edge where start is high and busy is low. busy is held low, so one
// vertex may enter every cycle and throughput is one vertex per clock.
// each request gives exactly one result on result, marked by done for a single
// cycle, as it leaves the last stage. the pipeline has 15 register stages:
// input, squares, sum, four square root stages (three bits each, two in the
// last), reciprocal multiply, divide correction, two weight multiplies, config
// products, position products, sum and saturation. results keep request order.
// the receiver cannot stall the block; every result must be taken when shown.
// registers sit on an apb port at byte address 4*i, pready is always high;
// the user ensures they are written only while no request is in flight, which
// the block leaves unchecked. reset clears the valid bits, loads register defaults.
`default_nettype none

module vertex_region_deform
    import vrd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire vrd_in_t     pos,
    output logic             done,
    output vrd_out_t         result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int NSTG = 15;
    localparam int NPOS = 13;

    // ---------------- configuration registers ----------------
    logic [14:0]        chin_scale_reg, brow_spread_reg, eye_scale_reg, nose_scale_reg;
    logic signed [15:0] brow_lift_reg, eye_spacing_reg, nose_extend_reg;
    logic [31:0]        cheek_ear_reg;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chin_scale_reg  <= 15'(Q_ONE);
            brow_lift_reg   <= '0;
            brow_spread_reg <= 15'(Q_ONE);
            eye_spacing_reg <= '0;
            eye_scale_reg   <= 15'(Q_ONE);
            nose_extend_reg <= '0;
            nose_scale_reg  <= 15'(Q_ONE);
            cheek_ear_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                CFG_CHIN_SCALE:  chin_scale_reg  <= pwdata[14:0];
                CFG_BROW_LIFT:   brow_lift_reg   <= pwdata[15:0];
                CFG_BROW_SPREAD: brow_spread_reg <= pwdata[14:0];
                CFG_EYE_SPACING: eye_spacing_reg <= pwdata[15:0];
                CFG_EYE_SCALE:   eye_scale_reg   <= pwdata[14:0];
                CFG_NOSE_EXTEND: nose_extend_reg <= pwdata[15:0];
                CFG_NOSE_SCALE:  nose_scale_reg  <= pwdata[14:0];
                CFG_CHEEK_EAR:   cheek_ear_reg   <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            CFG_CHIN_SCALE:  prdata = {17'd0, chin_scale_reg};
            CFG_BROW_LIFT:   prdata = {16'd0, brow_lift_reg};
            CFG_BROW_SPREAD: prdata = {17'd0, brow_spread_reg};
            CFG_EYE_SPACING: prdata = {16'd0, eye_spacing_reg};
            CFG_EYE_SCALE:   prdata = {17'd0, eye_scale_reg};
            CFG_NOSE_EXTEND: prdata = {16'd0, nose_extend_reg};
            CFG_NOSE_SCALE:  prdata = {17'd0, nose_scale_reg};
            CFG_CHEEK_EAR:   prdata = cheek_ear_reg;
            default:         prdata = '0;
        endcase
    end

    // ---------------- valid and position lines ----------------
    logic          vld_reg [NSTG];
    vrd_in_t       pos_reg [NPOS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start;
            for (int i = 1; i < NSTG; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg[0] <= pos;
        for (int i = 1; i < NPOS; i++)
            pos_reg[i] <= pos_reg[i-1];
    end

    // ---------------- per-region weight lanes ----------------
    logic [12:0] w_reg [NUM_REGIONS];

    for (genvar g = 0; g < NUM_REGIONS; g++)
    begin : g_region
        localparam int CX = REG_CX[g];
        localparam int CY = REG_CY[g];
        localparam int CZ = REG_CZ[g];
        localparam int RR = REG_R[g];
        localparam longint RC = REG_RECIP[g];

        logic signed [16:0] dx, dy, dz;
        logic signed [33:0] px, py, pz;
        logic [31:0]        sqx_reg, sqy_reg, sqz_reg;
        logic [32:0]        sum;
        logic [10:0]        root_reg [5];
        logic [21:0]        rem_reg  [5];
        logic               far_reg  [6];
        logic [22:0]        num, num_reg;
        logic [45:0]        qprod;
        logic [12:0]        q0_reg;
        logic [23:0]        qr, rem_d;
        logic [12:0]        t_reg, t9_reg;
        logic [24:0]        tt_reg;
        logic [38:0]        wprod;

        // stage 1: squared distances
        assign dx = 17'(pos_reg[0].pos_x) - 17'(CX);
        assign dy = 17'(pos_reg[0].pos_y) - 17'(CY);
        assign dz = 17'(pos_reg[0].pos_z) - 17'(CZ);
        assign px = dx * dx;
        assign py = dy * dy;
        assign pz = dz * dz;

        always_ff @(posedge clk)
        begin
            sqx_reg <= px[31:0];
            sqy_reg <= py[31:0];
            sqz_reg <= pz[31:0];
        end

        // stage 2: sum, and outside the sphere once it reaches r squared
        assign sum = 33'(sqx_reg) + 33'(sqy_reg) + 33'(sqz_reg);

        always_ff @(posedge clk)
        begin
            far_reg[0]  <= (sum >= 33'(RR * RR));
            rem_reg[0]  <= (sum >= 33'(RR * RR)) ? '0 : sum[21:0];
            root_reg[0] <= '0;
        end

        // stages 3 to 6: square root, three result bits per stage, two in the last
        for (genvar j = 1; j < 5; j++)
        begin : g_sqrt
            localparam int HI = 10 - 3 * (j - 1);
            logic [10:0] root_c;
            logic [23:0] rem_c;
            logic [23:0] term;

            always_comb
            begin
                root_c = root_reg[j-1];
                rem_c  = 24'(rem_reg[j-1]);
                term   = '0;
                for (int s = 0; s < 3; s++)
                begin
                    if (HI - s >= 0)
                    begin
                        term = (24'(root_c) << (HI - s + 1)) + (24'd1 << (2 * (HI - s)));
                        if (rem_c >= term)
                        begin
                            root_c = root_c | (11'd1 << (HI - s));
                            rem_c  = rem_c - term;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                root_reg[j] <= root_c;
                rem_reg[j]  <= rem_c[21:0];
                far_reg[j]  <= far_reg[j-1];
            end
        end

        // stage 7: quotient estimate of (r - d) * 4096 / r
        assign num   = {11'(RR) - root_reg[4], 12'd0};
        assign qprod = 46'(num) * 46'(RC);

        always_ff @(posedge clk)
        begin
            num_reg    <= num;
            q0_reg     <= qprod[44:32];
            far_reg[5] <= far_reg[4];
        end

        // stage 8: one correction step, estimate is at most one low; zero outside the sphere
        assign qr    = 24'(q0_reg) * 24'(RR);
        assign rem_d = 24'(num_reg) - qr;

        always_ff @(posedge clk)
        begin
            if (far_reg[5])
                t_reg <= '0;
            else if (rem_d >= 24'(RR))
                t_reg <= q0_reg + 13'd1;
            else
                t_reg <= q0_reg;
        end

        // stages 9 and 10: smoothstep t*t*(3 - 2t)
        always_ff @(posedge clk)
        begin
            tt_reg     <= 25'(t_reg) * 25'(t_reg);
            t9_reg     <= t_reg;
        end

        assign wprod = 39'(tt_reg) * 39'(14'd12288 - {t9_reg, 1'b0});

        always_ff @(posedge clk)
        begin
            w_reg[g]   <= wprod[36:24];
        end
    end

    // ---------------- stage 11: weight times config ----------------
    function automatic logic signed [17:0] wmul(input logic signed [16:0] a,
                                                 input logic [12:0] w);
        logic signed [31:0] p;
        p = 32'(a) * 32'(signed'({1'b0, w}));
        return p[29:12];
    endfunction

    function automatic logic signed [23:0] rmul(input logic signed [17:0] a,
                                                 input logic signed [17:0] b);
        logic signed [35:0] p;
        p = 36'(a) * 36'(b);
        return p[35:12];
    endfunction

    logic signed [16:0] chin_d, spread_d, eye_d, nose_d;
    logic signed [15:0] cheek_o, ear_o;

    assign chin_d   = 17'(chin_scale_reg) - 17'(Q_ONE);
    assign spread_d = 17'(brow_spread_reg) - 17'(Q_ONE);
    assign eye_d    = 17'(eye_scale_reg) - 17'(Q_ONE);
    assign nose_d   = 17'(nose_scale_reg) - 17'(Q_ONE);
    assign cheek_o  = cheek_ear_reg[15:0];
    assign ear_o    = cheek_ear_reg[31:16];

    logic signed [17:0] kc_reg, kb_reg, lift_reg, pushl_reg, pushr_reg, kel_reg, ker_reg;
    logic signed [17:0] dnose_reg, kn_reg, chkl_reg, chkr_reg, earl_reg, earr_reg;

    always_ff @(posedge clk)
    begin
        kc_reg    <= wmul(chin_d, w_reg[RG_CHIN]);
        kb_reg    <= wmul(spread_d, w_reg[RG_BROW]);
        lift_reg  <= wmul(17'(brow_lift_reg), w_reg[RG_BROW]);
        pushl_reg <= wmul(17'(eye_spacing_reg), w_reg[RG_EYE_L]);
        pushr_reg <= wmul(17'(eye_spacing_reg), w_reg[RG_EYE_R]);
        kel_reg   <= wmul(eye_d, w_reg[RG_EYE_L]);
        ker_reg   <= wmul(eye_d, w_reg[RG_EYE_R]);
        dnose_reg <= wmul(17'(nose_extend_reg), w_reg[RG_NOSE]);
        kn_reg    <= wmul(nose_d, w_reg[RG_NOSE]);
        chkl_reg  <= wmul(17'(cheek_o), w_reg[RG_CHEEK_L]);
        chkr_reg  <= wmul(17'(cheek_o), w_reg[RG_CHEEK_R]);
        earl_reg  <= wmul(17'(ear_o), w_reg[RG_EAR_L]);
        earr_reg  <= wmul(17'(ear_o), w_reg[RG_EAR_R]);
    end

    // ---------------- stage 12: position products ----------------
    vrd_in_t            op;
    logic signed [17:0] ex_l, ey_l, ez_l, ex_r, ey_r, ez_r, ex_n, ey_n, ez_n;

    assign op   = pos_reg[11];
    assign ex_l = 18'(op.pos_x) - 18'(REG_CX[RG_EYE_L]);
    assign ey_l = 18'(op.pos_y) - 18'(REG_CY[RG_EYE_L]);
    assign ez_l = 18'(op.pos_z) - 18'(REG_CZ[RG_EYE_L]);
    assign ex_r = 18'(op.pos_x) - 18'(REG_CX[RG_EYE_R]);
    assign ey_r = 18'(op.pos_y) - 18'(REG_CY[RG_EYE_R]);
    assign ez_r = 18'(op.pos_z) - 18'(REG_CZ[RG_EYE_R]);
    assign ex_n = 18'(op.pos_x) - 18'(REG_CX[RG_NOSE]);
    assign ey_n = 18'(op.pos_y) - 18'(REG_CY[RG_NOSE]);
    assign ez_n = 18'(op.pos_z) - 18'(REG_CZ[RG_NOSE]);

    logic signed [23:0] xsc_reg, ysc_reg;
    logic signed [23:0] rxl_reg, ryl_reg, rzl_reg, rxr_reg, ryr_reg, rzr_reg;
    logic signed [23:0] rxn_reg, ryn_reg, rzn_reg;
    logic signed [17:0] lift2_reg, pushl2_reg, pushr2_reg, dnose2_reg;
    logic signed [17:0] chkl2_reg, chkr2_reg, earl2_reg, earr2_reg;

    always_ff @(posedge clk)
    begin
        // chin scales y, brow scales x, both about the origin
        ysc_reg    <= rmul(18'(op.pos_y), kc_reg + 18'(Q_ONE));
        xsc_reg    <= rmul(18'(op.pos_x), kb_reg + 18'(Q_ONE));
        rxl_reg    <= rmul(ex_l, kel_reg);
        ryl_reg    <= rmul(ey_l, kel_reg);
        rzl_reg    <= rmul(ez_l, kel_reg);
        rxr_reg    <= rmul(ex_r, ker_reg);
        ryr_reg    <= rmul(ey_r, ker_reg);
        rzr_reg    <= rmul(ez_r, ker_reg);
        rxn_reg    <= rmul(ex_n, kn_reg);
        ryn_reg    <= rmul(ey_n, kn_reg);
        rzn_reg    <= rmul(ez_n, kn_reg);
        lift2_reg  <= lift_reg;
        pushl2_reg <= pushl_reg;
        pushr2_reg <= pushr_reg;
        dnose2_reg <= dnose_reg;
        chkl2_reg  <= chkl_reg;
        chkr2_reg  <= chkr_reg;
        earl2_reg  <= earl_reg;
        earr2_reg  <= earr_reg;
    end

    // ---------------- stage 13: sums, stage 14: saturation ----------------
    logic signed [25:0] sx_reg, sy_reg, sz_reg;

    always_ff @(posedge clk)
    begin
        sx_reg <= 26'(xsc_reg) - 26'(pushl2_reg) + 26'(rxl_reg) + 26'(pushr2_reg)
                  + 26'(rxr_reg) + 26'(rxn_reg);
        sy_reg <= 26'(ysc_reg) + 26'(lift2_reg) + 26'(ryl_reg) + 26'(ryr_reg)
                  + 26'(ryn_reg) + 26'(earl2_reg) + 26'(earr2_reg);
        sz_reg <= 26'(pos_reg[12].pos_z) + 26'(rzl_reg) + 26'(rzr_reg) + 26'(dnose2_reg)
                  + 26'(rzn_reg) + 26'(chkl2_reg) + 26'(chkr2_reg);
    end

    function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
        if (v > 26'sd32767)
            return 16'sh7fff;
        else if (v < -26'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    vrd_out_t result_reg;

    always_ff @(posedge clk)
    begin
        result_reg.new_x <= sat16(sx_reg);
        result_reg.new_y <= sat16(sy_reg);
        result_reg.new_z <= sat16(sz_reg);
    end

    assign result = result_reg;
    assign done   = vld_reg[NSTG-1];

endmodule

`default_nettype wire
